// ===== rtl/b64e_pkg.sv =====
// Shared types, constants and character helpers of the base64 escape encoder.
package b64e_pkg;

  // Default depth of the group queue between front and back
  localparam int unsigned GroupQueueDepth = 2;

  // Characters used by the encoder
  localparam logic [7:0] CharPad     = 8'h3D; // '='
  localparam logic [7:0] CharPercent = 8'h25; // '%'
  localparam logic [7:0] CharPlus    = 8'h2B; // '+'
  localparam logic [7:0] CharSlash   = 8'h2F; // '/'
  localparam logic [7:0] CharUpperA  = 8'h41; // 'A'
  localparam logic [7:0] CharLowerA  = 8'h61; // 'a'
  localparam logic [7:0] CharZero    = 8'h30; // '0'

  // Position inside a percent escape
  typedef enum logic [1:0] {
    EscPercent = 2'd0,
    EscHigh    = 2'd1,
    EscLow     = 2'd2
  } b64e_esc_e;

  // One encoded group: four characters, chars[0] goes out first
  typedef struct packed {
    logic [3:0][7:0] chars;
  } b64e_group_t;

  // Queue handshake from the front to the queue
  typedef struct packed {
    logic        push;
    b64e_group_t group;
  } b64e_push_t;

  // Queue status and head toward the back
  typedef struct packed {
    logic        valid;
    b64e_group_t group;
  } b64e_head_t;

  // Standard base64 alphabet
  function automatic logic [7:0] b64e_sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = CharUpperA + {2'b00, v};
    end else if (v < 6'd52) begin
      c = CharLowerA + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = CharZero + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = CharPlus;
    end else begin
      c = CharSlash;
    end
    return c;
  endfunction

  // Uppercase hex digit
  function automatic logic [7:0] b64e_hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = CharZero + {4'h0, n};
    end else begin
      c = CharUpperA + {4'h0, n} - 8'd10;
    end
    return c;
  endfunction

  // Letters, digits, '-', '_', '.' and '~' pass unescaped
  function automatic logic b64e_unreserved(input logic [7:0] c);
    logic r;
    r = ((c >= 8'h30) && (c <= 8'h39)) ||
        ((c >= 8'h41) && (c <= 8'h5A)) ||
        ((c >= 8'h61) && (c <= 8'h7A)) ||
        (c == 8'h2D) || (c == 8'h5F) || (c == 8'h2E) || (c == 8'h7E);
    return r;
  endfunction

endpackage

// ===== rtl/base64_url_escape_encoder.sv =====
// A group's first character passes the group queue, the current-group register and the output
// register before it is shown. The back end emits one character per cycle while output is not
// stalled and a group waits; a full group is 4 characters (3 bytes) plain and up to 12 escaped.
// Input is taken every cycle while the group queue has room, even while output stalls.
// Reset (rst_ni low, asynchronous) empties held bytes, queue and output; url_escape resets to 1.
// Top level of the streaming base64 encoder with optional percent-escaping.
module base64_url_escape_encoder import b64e_pkg::*; #(
  parameter int unsigned QueueDepth = GroupQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_url_escape_i
);

  logic       url_escape_q;
  logic       full, pop, accept;
  b64e_push_t push;
  b64e_head_t head;

  // Config register, always writable
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      url_escape_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      url_escape_q <= cfg_url_escape_i;
    end
  end

  // Hold off requests while the queue is full
  assign in_stall_o = full;
  assign accept     = in_valid_i && !in_stall_o;

  b64e_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i     (accept),
    .data_byte_i,
    .final_byte_i,
    .push_o       (push)
  );

  b64e_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .full_o (full)
  );

  b64e_back u_back (
    .clk_i,
    .rst_ni,
    .url_escape_i (url_escape_q),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o,
    .out_stall_i,
    .out_char_o,
    .out_last_o
  );

endmodule

// ===== rtl/b64e_front.sv =====
// Front end: accepts bytes, holds partial groups, builds four-character groups.
module b64e_front import b64e_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output b64e_push_t push_o
);

  logic [15:0] held_q, held_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [23:0] v;

  // Group assembly and padding
  always_comb begin
    held_d = held_q;
    cnt_d  = cnt_q;
    v      = '0;
    push_o = '0;
    if (accept_i) begin
      if (cnt_q == 2'd2) begin
        v      = {held_q, data_byte_i};
        push_o.push = 1'b1;
        for (int i = 0; i < 4; i++) begin
          push_o.group.chars[i] = b64e_sextet_char(v[23 - 6*i -: 6]);
        end
        held_d = '0;
        cnt_d  = 2'd0;
      end else begin
        if (cnt_q == 2'd0) begin
          held_d = {data_byte_i, 8'h00};
        end else begin
          held_d = {held_q[15:8], data_byte_i};
        end
        cnt_d = cnt_q + 2'd1;
        if (final_byte_i) begin
          v = {held_d, 8'h00};
          push_o.push = 1'b1;
          push_o.group.chars[0] = b64e_sextet_char(v[23:18]);
          push_o.group.chars[1] = b64e_sextet_char(v[17:12]);
          // one-byte tail gets two pads, two-byte tail one
          push_o.group.chars[2] = (cnt_q == 2'd0) ? CharPad : b64e_sextet_char(v[11:6]);
          push_o.group.chars[3] = CharPad;
          held_d = '0;
          cnt_d  = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cnt_q  <= '0;
    end else begin
      held_q <= held_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== rtl/b64e_queue.sv =====
// Small group queue that decouples the front end from the character emitter.
module b64e_queue import b64e_pkg::*; #(
  parameter int unsigned Depth = GroupQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  b64e_push_t push_i,
  input  logic       pop_i,
  output b64e_head_t head_o,
  output logic       full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  b64e_group_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_pop;

  assign do_pop        = pop_i && (cnt_q != '0);
  assign full_o        = (cnt_q == FullCnt);
  assign head_o.valid  = (cnt_q != '0);
  assign head_o.group  = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_q] <= push_i.group;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i.push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!push_i.push && do_pop) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/b64e_back.sv =====
// Back end: walks each group character by character, percent-escapes when URL escaping is on, registers output.
module b64e_back import b64e_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       url_escape_i,
  input  b64e_head_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);

  b64e_group_t cur_q, cur_d;
  logic        cur_valid_q, cur_valid_d;
  logic [1:0]  idx_q, idx_d;
  b64e_esc_e   esc_q, esc_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_char_q, out_char_d;
  logic        out_last_q, out_last_d;

  logic [7:0]  ch;
  logic        escape, char_done, grp_done, advance, emit;

  // Character walk and escape sequencing
  always_comb begin
    ch        = cur_q.chars[idx_q];
    escape    = url_escape_i && !b64e_unreserved(ch);
    char_done = !escape || (esc_q == EscLow);
    grp_done  = char_done && (idx_q == 2'd3);
    advance   = !out_valid_q || !out_stall_i;
    emit      = cur_valid_q && advance;

    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    esc_d       = esc_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    pop_o       = 1'b0;

    if (advance) begin
      out_valid_d = cur_valid_q;
      out_last_d  = grp_done;
      if (!escape) begin
        out_char_d = ch;
      end else begin
        unique case (esc_q)
          EscPercent: out_char_d = CharPercent;
          EscHigh:    out_char_d = b64e_hex_char(ch[7:4]);
          EscLow:     out_char_d = b64e_hex_char(ch[3:0]);
          default:    out_char_d = CharPercent;
        endcase
      end
    end

    if (emit) begin
      if (char_done) begin
        esc_d = EscPercent;
        idx_d = idx_q + 2'd1;
      end else begin
        esc_d = (esc_q == EscPercent) ? EscHigh : EscLow;
      end
      if (grp_done) begin
        cur_valid_d = 1'b0;
      end
    end

    // Take the next group as soon as the current one finishes
    if (head_i.valid && (!cur_valid_q || (emit && grp_done))) begin
      pop_o       = 1'b1;
      cur_d       = head_i.group;
      cur_valid_d = 1'b1;
      idx_d       = 2'd0;
      esc_d       = EscPercent;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      esc_q       <= EscPercent;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      esc_q       <= esc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/b64e_checker.sv =====
// Port-level checks of the base64 escape encoder and their binding.
module b64e_checker import b64e_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_char_o,
  input logic       out_last_o,
  input logic       cfg_ready_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_char_o) && $stable(out_last_o))
    else $error("stalled output changed");

  // An escape never ends a group
  a_pct_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_char_o == CharPercent) |-> !out_last_o)
    else $error("percent sign flagged last");

  // The hex digits follow a taken percent sign without a gap
  a_pct_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (out_char_o == CharPercent) |=> out_valid_o)
    else $error("gap inside escape");

  // The config port never blocks
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind base64_url_escape_encoder b64e_checker u_b64e_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_char_o  (out_char_o),
  .out_last_o  (out_last_o),
  .cfg_ready_o (cfg_ready_o)
);
